@@ src/utu_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types, constants and the fixed decoder tables: the byte class map and
// the class-by-row transition table of the UTF-8 state machine.
// ----------------------------------------------------------------------------
package utu_pkg;

	// Decoder rows: row 0 is accept, row 1 is reject, rows 2 to 8 sit inside
	// a multi-byte character.
	localparam int unsigned NumRows    = 9;
	localparam int unsigned NumClasses = 12;

	typedef logic [3:0]  row_t;
	typedef logic [3:0]  class_t;
	typedef logic [20:0] codepoint_t;
	typedef logic [15:0] unit_t;

	localparam row_t RowAccept = 4'd0;
	localparam row_t RowReject = 4'd1;

	localparam unit_t HighBase = 16'hD7C0;
	localparam unit_t LowBase  = 16'hDC00;

	// What one decoded byte produces: nothing, one unit, or a surrogate pair.
	typedef struct packed {
		logic  emit;
		logic  pair;
		unit_t unit0;
		unit_t unit1;
	} unit_info_t;

	// Next row, indexed by current row and byte class.
	localparam row_t NextRow [NumRows][NumClasses] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
		'{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
		'{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
	};

	// Map a raw byte to its character class.
	function automatic class_t byte_class(input logic [7:0] b);
		class_t cls;
		if (b < 8'h80)       cls = 4'd0;
		else if (b < 8'h90)  cls = 4'd1;
		else if (b < 8'hA0)  cls = 4'd9;
		else if (b < 8'hC0)  cls = 4'd7;
		else if (b < 8'hC2)  cls = 4'd8;
		else if (b < 8'hE0)  cls = 4'd2;
		else if (b == 8'hE0) cls = 4'd10;
		else if (b == 8'hED) cls = 4'd4;
		else if (b < 8'hF0)  cls = 4'd3;
		else if (b == 8'hF0) cls = 4'd11;
		else if (b < 8'hF4)  cls = 4'd6;
		else if (b == 8'hF4) cls = 4'd5;
		else                 cls = 4'd8;
		return cls;
	endfunction

endpackage

@@ src/utu_byte_if.sv @@
// ----------------------------------------------------------------------------
// UTF-8 byte channel
// Valid/ready channel that carries one raw UTF-8 byte per transaction.
// ----------------------------------------------------------------------------
interface utu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_of_string;

	modport source (output valid, output in_byte, output start_of_string, input ready);
	modport sink (input valid, input in_byte, input start_of_string, output ready);
endinterface

@@ src/utu_unit_if.sv @@
// ----------------------------------------------------------------------------
// UTF-16 unit channel
// Valid/ready channel that carries one UTF-16 code unit per transaction.
// ----------------------------------------------------------------------------
interface utu_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_unit;

	modport source (output valid, output code_unit, output last_unit, input ready);
	modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

@@ src/utu_dfa.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder state machine
// Holds the decoder row and the partial code point, decodes one byte per
// advance and reports the UTF-16 units that the byte completes.
// ----------------------------------------------------------------------------
module utu_dfa (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          in_byte,
	input  logic                start_of_string,
	output utu_pkg::unit_info_t info
);

	utu_pkg::row_t       row_q;
	utu_pkg::codepoint_t cp_q;
	utu_pkg::row_t       cur_row;
	utu_pkg::codepoint_t cur_cp;
	utu_pkg::class_t     cls;
	utu_pkg::row_t       next_row;
	utu_pkg::codepoint_t next_cp;
	logic [7:0]          lead_mask;

	// Start of string forces the accept row and a cleared code point.
	always_comb begin
		cur_row   = start_of_string ? utu_pkg::RowAccept : row_q;
		cur_cp    = start_of_string ? '0 : cp_q;
		cls       = utu_pkg::byte_class(in_byte);
		lead_mask = 8'hFF >> cls;
		next_row  = utu_pkg::NextRow[cur_row][cls];
		if (cur_row != utu_pkg::RowAccept) begin
			next_cp = {cur_cp[14:0], in_byte[5:0]};
		end else begin
			next_cp = {13'd0, lead_mask & in_byte};
		end
	end

	// A return to the accept row completes a character.
	always_comb begin
		info.emit  = (next_row == utu_pkg::RowAccept);
		info.pair  = (next_cp[20:16] != 5'd0);
		info.unit0 = info.pair ? utu_pkg::HighBase + {5'd0, next_cp[20:10]} : next_cp[15:0];
		info.unit1 = utu_pkg::LowBase + {6'd0, next_cp[9:0]};
	end

	// Decoder state advances once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= utu_pkg::RowAccept;
			cp_q  <= '0;
		end else if (advance) begin
			row_q <= next_row;
			cp_q  <= next_cp;
		end
	end

endmodule

@@ src/utf8_to_utf16_transcoder.sv @@
// Throughput: one byte per cycle while the output channel takes units; a surrogate pair
// holds the input back until its low surrogate has moved up into the output register.
// An input register and an output register with one extra slot for the low surrogate
// decouple the two channels.
// Reset clears all valid flags and puts the decoder in the accept state.
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Decodes a UTF-8 byte stream and emits UTF-16 code units, one unit per
// BMP character and a surrogate pair for characters above the BMP.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
	input  logic      clk,
	input  logic      arst_n,
	utu_byte_if.sink  bytes,
	utu_unit_if.source units
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 sos_s1;
	logic                 out_valid_q;
	logic                 out_last_q;
	utu_pkg::unit_t       out_unit_q;
	logic                 pend_valid_q;
	utu_pkg::unit_t       pend_unit_q;
	logic                 out_free;
	logic                 adv_s1;
	utu_pkg::unit_info_t  info;

	// The output slot can take new work when no low surrogate waits and the
	// current unit is gone or leaving.
	assign out_free     = !pend_valid_q && (!out_valid_q || units.ready);
	assign adv_s1       = valid_s1 && out_free;
	assign bytes.ready  = !valid_s1 || adv_s1;

	assign units.valid     = out_valid_q;
	assign units.code_unit = out_unit_q;
	assign units.last_unit = out_last_q;

	utu_dfa u_dfa (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (adv_s1),
		.in_byte         (byte_s1),
		.start_of_string (sos_s1),
		.info            (info)
	);

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
			sos_s1  <= bytes.start_of_string;
		end
	end

	// Output valid flags: the low surrogate moves up once the high one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (pend_valid_q && units.ready) begin
			pend_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q  <= info.emit;
			pend_valid_q <= info.emit && info.pair;
		end else if (units.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (pend_valid_q && units.ready) begin
			out_unit_q <= pend_unit_q;
			out_last_q <= 1'b1;
		end else if (adv_s1) begin
			out_unit_q  <= info.unit0;
			out_last_q  <= !info.pair;
			pend_unit_q <= info.unit1;
		end
	end

endmodule

@@ src/utu_checker.sv @@
// ----------------------------------------------------------------------------
// Transcoder port checker
// Watches the output channel of the transcoder for surrogate pairing and
// stall behavior, and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module utu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_unit,
	input logic        last_unit
);

	// A stalled unit holds its value until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(last_unit))
		else $error("output unit changed while stalled");

	// A unit that is not the last one of its byte is always a high surrogate.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_unit |-> code_unit[15:10] == 6'b110110)
		else $error("non-final unit is not a high surrogate");

	// A taken high surrogate is followed at once by its low surrogate.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_unit |=>
			out_valid && last_unit && code_unit[15:10] == 6'b110111)
		else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_transcoder utu_checker u_utu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (units.valid),
	.out_ready (units.ready),
	.code_unit (units.code_unit),
	.last_unit (units.last_unit)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// Streams UTF-8 bytes into the transcoder through its byte channel and checks
// every UTF-16 unit on its unit channel against a scoreboard that decodes the
// same byte stream. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

	// Decoder rows as this testbench names them; accept and reject come from
	// the package.
	localparam utu_pkg::row_t RowNeed1 = 4'd2;  // one continuation byte left
	localparam utu_pkg::row_t RowNeed2 = 4'd3;  // two continuation bytes left
	localparam utu_pkg::row_t RowE0    = 4'd4;  // after E0, next byte must be A0..BF
	localparam utu_pkg::row_t RowEd    = 4'd5;  // after ED, next byte must be 80..9F
	localparam utu_pkg::row_t RowF0    = 4'd6;  // after F0, next byte must be 90..BF
	localparam utu_pkg::row_t RowNeed3 = 4'd7;  // after F1..F3, three bytes left
	localparam utu_pkg::row_t RowF4    = 4'd8;  // after F4, next byte must be 80..8F

	// Byte classes.
	localparam int ClsAscii  = 0;
	localparam int ClsCont80 = 1;  // 80..8F
	localparam int ClsLead2  = 2;  // C2..DF
	localparam int ClsLead3  = 3;  // E1..EC, EE, EF
	localparam int ClsEd     = 4;
	localparam int ClsF4     = 5;
	localparam int ClsLead4  = 6;  // F1..F3
	localparam int ClsContA0 = 7;  // A0..BF
	localparam int ClsBad    = 8;  // C0, C1, F5..FF
	localparam int ClsCont90 = 9;  // 90..9F
	localparam int ClsE0     = 10;
	localparam int ClsF0     = 11;

	localparam int RandomBytes = 700;

	// Scoreboard: decodes each accepted byte and holds the units it must cause.
	class utf16_scoreboard;
		typedef struct packed {
			utu_pkg::unit_t value;
			logic           last;
		} unit_due_t;

		utu_pkg::row_t       row;
		utu_pkg::codepoint_t partial;
		unit_due_t           units_due[$];
		int                  errors;

		function new();
			row = utu_pkg::RowAccept;
			partial = '0;
			errors = 0;
		endfunction

		function int char_class(logic [7:0] b);
			if (b <= 8'h7F) return ClsAscii;
			if (b <= 8'h8F) return ClsCont80;
			if (b <= 8'h9F) return ClsCont90;
			if (b <= 8'hBF) return ClsContA0;
			if (b <= 8'hC1) return ClsBad;
			if (b <= 8'hDF) return ClsLead2;
			if (b == 8'hE0) return ClsE0;
			if (b == 8'hED) return ClsEd;
			if (b <= 8'hEF) return ClsLead3;
			if (b == 8'hF0) return ClsF0;
			if (b <= 8'hF3) return ClsLead4;
			if (b == 8'hF4) return ClsF4;
			return ClsBad;
		endfunction

		function utu_pkg::row_t next_row(utu_pkg::row_t r, int cls);
			logic          any_cont;
			utu_pkg::row_t nxt;
			any_cont = (cls == ClsCont80) || (cls == ClsCont90) || (cls == ClsContA0);
			nxt = utu_pkg::RowReject;
			case (r)
				utu_pkg::RowAccept: begin
					case (cls)
						ClsAscii: nxt = utu_pkg::RowAccept;
						ClsLead2: nxt = RowNeed1;
						ClsLead3: nxt = RowNeed2;
						ClsE0:    nxt = RowE0;
						ClsEd:    nxt = RowEd;
						ClsF0:    nxt = RowF0;
						ClsLead4: nxt = RowNeed3;
						ClsF4:    nxt = RowF4;
						default:  nxt = utu_pkg::RowReject;
					endcase
				end
				RowNeed1: if (any_cont) nxt = utu_pkg::RowAccept;
				RowNeed2: if (any_cont) nxt = RowNeed1;
				RowE0:    if (cls == ClsContA0) nxt = RowNeed1;
				RowEd:    if (cls == ClsCont80 || cls == ClsCont90) nxt = RowNeed1;
				RowF0:    if (cls == ClsCont90 || cls == ClsContA0) nxt = RowNeed2;
				RowNeed3: if (any_cont) nxt = RowNeed2;
				RowF4:    if (cls == ClsCont80) nxt = RowNeed2;
				// Reject and any stray row value stay in reject.
				default:  nxt = utu_pkg::RowReject;
			endcase
			return nxt;
		endfunction

		// Decode one accepted byte and queue the units it completes.
		function void note_byte(logic [7:0] b, logic sos);
			int             cls;
			utu_pkg::unit_t hi;
			utu_pkg::unit_t lo;
			if (sos) begin
				row = utu_pkg::RowAccept;
				partial = '0;
			end
			cls = char_class(b);
			if (row != utu_pkg::RowAccept)
				partial = {partial[14:0], b[5:0]};
			else
				partial = utu_pkg::codepoint_t'((8'hFF >> cls) & b);
			row = next_row(row, cls);
			if (row == utu_pkg::RowAccept) begin
				if (partial <= 21'h00FFFF) begin
					units_due.push_back('{value: partial[15:0], last: 1'b1});
				end else begin
					hi = utu_pkg::HighBase + utu_pkg::unit_t'(partial >> 10);
					lo = utu_pkg::LowBase + utu_pkg::unit_t'(partial[9:0]);
					units_due.push_back('{value: hi, last: 1'b0});
					units_due.push_back('{value: lo, last: 1'b1});
				end
			end
		endfunction

		// Compare one received unit with the oldest one due.
		function void check_unit(utu_pkg::unit_t u, logic last);
			unit_due_t due;
			if (units_due.size() == 0) begin
				$error("unexpected code unit %h with last_unit %b", u, last);
				errors++;
				return;
			end
			due = units_due.pop_front();
			if (u !== due.value) begin
				$error("code_unit mismatch: expected %h, actual %h", due.value, u);
				errors++;
			end
			if (last !== due.last) begin
				$error("last_unit mismatch: expected %b, actual %b", due.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return units_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	utu_byte_if byte_ch ();
	utu_unit_if unit_ch ();

	utf8_to_utf16_transcoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.units  (unit_ch)
	);

	utf16_scoreboard sb = new();

	int bytes_sent = 0;
	int units_taken = 0;
	bit fast_in = 0;
	bit fast_out = 0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Offer one byte after a random gap and wait for its transaction.
	task automatic send_byte(input logic [7:0] b, input logic sos);
		int gap;
		gap = fast_in ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.in_byte <= b;
		byte_ch.start_of_string <= sos;
		do @(posedge clk); while (!byte_ch.ready);
		sb.note_byte(b, sos);
		bytes_sent++;
		if (bytes_sent % 40 == 0)
			fast_in = ($urandom_range(0, 3) == 0);
	endtask

	// Encode a code point as UTF-8 and send it, leaving off the last drop bytes but never the lead byte.
	task automatic send_char(input utu_pkg::codepoint_t cp, input logic sos, input int drop);
		logic [7:0] seq [4];
		int         n;
		int         keep;
		if (cp < 21'h80) begin
			n = 1;
			seq[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			n = 2;
			seq[0] = {3'b110, cp[10:6]};
		end else if (cp < 21'h10000) begin
			n = 3;
			seq[0] = {4'b1110, cp[15:12]};
		end else begin
			n = 4;
			seq[0] = {5'b11110, cp[20:18]};
		end
		if (n == 4) seq[1] = {2'b10, cp[17:12]};
		if (n >= 3) seq[n - 2] = {2'b10, cp[11:6]};
		if (n >= 2) seq[n - 1] = {2'b10, cp[5:0]};
		keep = n - ((drop > n - 1) ? n - 1 : drop);
		for (int i = 0; i < keep; i++)
			send_byte(seq[i], (i == 0) ? sos : ($urandom_range(0, 49) == 0));
	endtask

	// Pick a scalar value, weighted toward the lead bytes with narrow ranges.
	function automatic utu_pkg::codepoint_t random_cp();
		utu_pkg::codepoint_t cp;
		case ($urandom_range(0, 9))
			0, 1, 2: cp = utu_pkg::codepoint_t'($urandom_range(0, 'h7F));
			3, 4:    cp = utu_pkg::codepoint_t'($urandom_range('h80, 'h7FF));
			5:       cp = utu_pkg::codepoint_t'($urandom_range('h800, 'hFFF));
			6:       cp = utu_pkg::codepoint_t'($urandom_range('hD000, 'hD7FF));
			7: begin
				cp = utu_pkg::codepoint_t'($urandom_range('h1000, 'hFFFF));
				// Surrogate values have no UTF-8 form; move them out of range.
				if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 21'h8000;
			end
			8:       cp = utu_pkg::codepoint_t'($urandom_range('h10000, 'h3FFFF));
			default: cp = utu_pkg::codepoint_t'($urandom_range('h10000, 'h10FFFF));
		endcase
		return cp;
	endfunction

	// Send something malformed: stray bytes, a cut-off character or a bad form.
	task automatic send_noise();
		utu_pkg::codepoint_t cp;
		case ($urandom_range(0, 2))
			0: begin
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end
			1: begin
				do cp = random_cp(); while (cp < 21'h80);
				send_char(cp, $urandom_range(0, 1) == 1, $urandom_range(1, 3));
			end
			default: begin
				case ($urandom_range(0, 3))
					0: send_byte(8'($urandom_range(8'hC0, 8'hC1)), 1'b0);
					1: send_byte(8'($urandom_range(8'hF5, 8'hFF)), 1'b0);
					2: send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
					default: begin
						// Encoded surrogate: ED followed by A0..BF.
						send_byte(8'hED, 1'b0);
						send_byte(8'($urandom_range(8'hA0, 8'hBF)), 1'b0);
					end
				endcase
				send_byte(8'($urandom_range(0, 255)), 1'b0);
			end
		endcase
	endtask

	// Accept one unit after a random stall and check it.
	task automatic take_unit();
		int gap;
		gap = fast_out ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			unit_ch.ready <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		unit_ch.ready <= 1'b1;
		do @(posedge clk); while (!unit_ch.valid);
		sb.check_unit(unit_ch.code_unit, unit_ch.last_unit);
		units_taken++;
		if (units_taken % 40 == 0)
			fast_out = ($urandom_range(0, 3) == 0);
	endtask

	// Unit receiver.
	initial begin
		unit_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever take_unit();
	end

	// Reset, stimulus and the final verdict.
	initial begin
		bit after_noise;
		int waited;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.in_byte <= '0;
		byte_ch.start_of_string <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ASCII extremes.
		send_byte(8'h00, 1'b1);
		send_byte(8'h7F, 1'b0);
		// Two-byte extremes.
		send_byte(8'hC2, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hDF, 1'b0);
		send_byte(8'hBF, 1'b0);
		// Three-byte forms: after E0, the last before the surrogates, top of BMP.
		send_byte(8'hE0, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hED, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		// Four-byte extremes give surrogate pairs.
		send_byte(8'hF0, 1'b0);
		send_byte(8'h90, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hF4, 1'b0);
		send_byte(8'h8F, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		// A malformed byte sticks in reject until start of string.
		send_byte(8'hC0, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b1);
		// Start of string in the middle of a character drops it.
		send_byte(8'hE2, 1'b0);
		send_byte(8'h42, 1'b1);

		// Random stream: mostly well-formed characters, some malformed input.
		after_noise = 0;
		while (bytes_sent < 28 + RandomBytes) begin
			if ($urandom_range(0, 6) == 0) begin
				send_noise();
				after_noise = 1;
			end else begin
				send_char(random_cp(),
					after_noise ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) == 0),
					0);
				after_noise = 0;
			end
		end
		byte_ch.valid <= 1'b0;

		// Drain the outstanding units, then watch for stray ones.
		waited = 0;
		while (sb.pending() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d code units never arrived", sb.pending());
			sb.errors++;
		end

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
